// ===== src/mssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssr_pkg: shared types and constants for the servo slew ramp unit
// Command codes, home values, stream widths and the controller command bundle.
// ----------------------------------------------------------------------------
package mssr_pkg;

	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam int POS_W   = 8;
	localparam int CHAN_W  = 3;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 16;

	localparam logic [POS_W-1:0] HOME_POS  = 8'd90;
	localparam logic [POS_W-1:0] HOME_STEP = 8'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the incoming transfer fields
		logic do_set;    // store target and step, load a status result
		logic do_step;   // step the indexed channel, load its result
		logic step_last; // the indexed channel is the final one of a tick
	} dp_cmd_t;

endpackage

// ===== src/mssr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssr_ctrl: command sequencer
// Accepts one command at a time, walks the channels on a tick and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module mssr_ctrl #(
	parameter int CHANNELS = 6,
	parameter int IDX_W    = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tuser,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output mssr_pkg::dp_cmd_t  cmd,
	output logic [IDX_W-1:0]   idx
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET,
		ST_TICK
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             out_free;
	logic             is_last;

	assign out_free = !out_valid_q || m_tready;
	assign is_last  = (idx_q == IDX_W'(CHANNELS - 1));
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign idx      = idx_q;

	always_comb begin
		cmd.capture   = s_tvalid && (state_q == ST_IDLE);
		cmd.do_set    = (state_q == ST_SET) && out_free;
		cmd.do_step   = (state_q == ST_TICK) && out_free;
		cmd.step_last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_set || cmd.do_step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (s_tvalid) begin
						state_q <= (s_tuser == mssr_pkg::CMD_TICK) ? ST_TICK : ST_SET;
					end
				end
				ST_SET: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (out_free) begin
						idx_q <= is_last ? '0 : idx_q + 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/mssr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssr_dp: channel state and step datapath
// Per-channel position, target and step registers, one shared step unit and
// the output result register.
// ----------------------------------------------------------------------------
module mssr_dp #(
	parameter int CHANNELS = 6,
	parameter int IDX_W    = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mssr_pkg::dp_cmd_t             cmd,
	input  logic [IDX_W-1:0]              idx,
	input  logic [mssr_pkg::S_DATA_W-1:0] s_tdata,
	output logic [mssr_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	logic [mssr_pkg::POS_W-1:0]  cur_q [CHANNELS];
	logic [mssr_pkg::POS_W-1:0]  tgt_q [CHANNELS];
	logic [mssr_pkg::POS_W-1:0]  stp_q [CHANNELS];

	logic [mssr_pkg::CHAN_W-1:0] chan_q;
	logic [mssr_pkg::POS_W-1:0]  target_q;
	logic [mssr_pkg::POS_W-1:0]  speed_q;
	logic                        moving_q;

	logic [mssr_pkg::M_DATA_W-1:0] data_q;
	logic                          last_q;

	logic                        chan_ok;
	logic [mssr_pkg::POS_W-1:0]  cur;
	logic [mssr_pkg::POS_W-1:0]  dst;
	logic [mssr_pkg::POS_W-1:0]  st;
	logic [mssr_pkg::POS_W:0]    sum;
	logic [mssr_pkg::POS_W-1:0]  diff;
	logic [mssr_pkg::POS_W-1:0]  nxt;
	logic                        moving;

	assign chan_ok = ({1'b0, chan_q} < (mssr_pkg::CHAN_W + 1)'(CHANNELS));

	assign cur  = cur_q[idx];
	assign dst  = tgt_q[idx];
	assign st   = stp_q[idx];
	assign sum  = {1'b0, cur} + {1'b0, st};
	assign diff = cur - st;

	// Step toward target; land on it when the step would reach or pass it.
	always_comb begin
		moving = 1'b1;
		if (cur < dst) begin
			nxt = (sum < {1'b0, dst}) ? sum[mssr_pkg::POS_W-1:0] : dst;
		end else if (cur > dst) begin
			nxt = ((st < cur) && (diff > dst)) ? diff : dst;
		end else begin
			nxt    = cur;
			moving = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i] <= mssr_pkg::HOME_POS;
				tgt_q[i] <= mssr_pkg::HOME_POS;
				stp_q[i] <= mssr_pkg::HOME_STEP;
			end
			moving_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				moving_q <= 1'b0;
			end
			if (cmd.do_set && chan_ok) begin
				tgt_q[chan_q[IDX_W-1:0]] <= target_q;
				stp_q[chan_q[IDX_W-1:0]] <= speed_q;
			end
			if (cmd.do_step) begin
				cur_q[idx] <= nxt;
				moving_q   <= moving_q | moving;
			end
		end
	end

	// Input field latch and result register: payload only.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			chan_q   <= s_tdata[2:0];
			target_q <= s_tdata[10:3];
			speed_q  <= s_tdata[18:11];
		end
		if (cmd.do_set) begin
			data_q <= {2'b00, 1'b0, 1'b0, 8'd0, chan_q, !chan_ok};
			last_q <= 1'b1;
		end else if (cmd.do_step) begin
			data_q <= {2'b00, cmd.step_last & (moving_q | moving), moving, nxt,
				mssr_pkg::CHAN_W'(idx), 1'b0};
			last_q <= cmd.step_last;
		end
	end

	assign m_tdata = data_q;
	assign m_tlast = last_q;

endmodule

// ===== src/multichannel_servo_slew_ramp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_servo_slew_ramp_unit: per-channel servo position ramp
// Set commands store a target and step for one channel; tick commands move
// every channel one step toward its target and report each channel.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                       | tuser   | tlast
//  ---------+-----+------------------------------------------+---------+------------
//  s_ (cmd) | in  | channel[2:0] target[10:3] speed[18:11]   | command | -
//  m_ (res) | out | status[0] out_channel[3:1] position[11:4]| -       | last result
//           |     | written[12] any_moving[13]               |         |
//
//  A set command first accepts the transfer, then stores the target and step
//  and loads the status result.
//  A tick accepts the transfer, then a single step unit reads and rewrites
//  one channel's state per cycle unless stalled, producing one result transfer per cycle.
//  A stall on m_tready holds the sequencer until the result register frees.
//  Reset puts every channel at position 90 with target 90 and step 1; the
//  block is ready as soon as reset is released.
//
module multichannel_servo_slew_ramp_unit #(
	parameter int CHANNELS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // channel[2:0], target[10:3], speed[18:11]
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status, out_channel, position, written, any_moving
	output logic        m_tlast
);

	// Channel index width; a single channel still needs one bit.
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	mssr_pkg::dp_cmd_t cmd;
	logic [IDX_W-1:0]  idx;

	// Sequencer: one command at a time, one channel per cycle on a tick while the result is not stalled.
	mssr_ctrl #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.idx      (idx)
	);

	// Channel state, step unit and result register.
	mssr_dp #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.idx     (idx),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// ===== src/mssr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssr_checker: port-level checks for the servo slew ramp unit
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module mssr_checker #(
	parameter int CHANNELS = 6
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A rejected set names an out-of-range channel and ends its item.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tlast && ({1'b0, m_tdata[3:1]} >= 4'(CHANNELS)))
		else $error("bad status on in-range channel");

	// The moving summary only rides on the final result.
	a_moving_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tlast)
		else $error("any_moving set before last result");

	// After a command transfer the unit is busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("new command taken while working");

	// A waiting command stays offered and unchanged.
	a_hold_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("command changed while waiting");

endmodule

bind multichannel_servo_slew_ramp_unit mssr_checker #(
	.CHANNELS (CHANNELS)
) u_mssr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
